### hdl/dhkv_pkg.sv
`timescale 1ns / 1ps
package dhkv_pkg;

    // Table geometry
    localparam int MAX_BUCKETS      = 256;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int SLOT_W  = $clog2(SLOTS_PER_BUCKET);
    localparam int SCNT_W  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int ADDR_W  = BKT_W + SLOT_W;
    localparam int ENTRIES = MAX_BUCKETS * SLOTS_PER_BUCKET;

    // Field widths
    localparam int CNT_W   = 9;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;
    localparam int DCNT_W  = $clog2(KEY_W);

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } dhkv_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] found_value;
    } dhkv_out_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic fix;
        logic scan_step;
        logic commit;
    } dhkv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic scan_done;
    } dhkv_sts_t;

endpackage

### hdl/dhkv_ctrl.sv
`timescale 1ns / 1ps
module dhkv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dhkv_pkg::dhkv_sts_t sts,
    output dhkv_pkg::dhkv_cmd_t cmd
);
    import dhkv_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DIV    = 6'b000100,
        S_FIX    = 6'b001000,
        S_SCAN   = 6'b010000,
        S_COMMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### hdl/dhkv_dp.sv
`timescale 1ns / 1ps
module dhkv_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dhkv_pkg::dhkv_cmd_t     cmd,
    output dhkv_pkg::dhkv_sts_t     sts,
    input  dhkv_pkg::dhkv_in_t      req,
    input  logic                    cfg_we,
    input  logic [dhkv_pkg::CNT_W-1:0] cfg_data,
    output logic                    done,
    output dhkv_pkg::dhkv_out_t     rsp
);
    import dhkv_pkg::*;

    // Storage: per-bucket valid row, per-slot key and value
    logic [SLOTS_PER_BUCKET-1:0] vmem [MAX_BUCKETS];
    logic [KEY_W-1:0]            kmem [ENTRIES];
    logic [VAL_W-1:0]            valmem [ENTRIES];

    logic [CNT_W-1:0]  bcount_reg;
    logic [BKT_W-1:0]  clr_cnt_reg;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              neg_reg;
    logic [KEY_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [SCNT_W-1:0] scnt_reg;
    logic              cmp_en_reg;
    logic [SLOT_W-1:0] prev_idx_reg;
    logic [SLOTS_PER_BUCKET-1:0] row_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [VAL_W-1:0]  rd_val_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [VAL_W-1:0]  hit_val_reg;
    logic              done_reg;
    dhkv_out_t         rsp_reg;

    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    trial;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              hit_now;
    logic              vmem_we;
    logic [BKT_W-1:0]  vmem_waddr;
    logic [SLOTS_PER_BUCKET-1:0] vmem_wdata;
    logic              kv_we;
    logic [ADDR_W-1:0] kv_raddr;
    logic [1:0]        status_c;
    logic [VAL_W-1:0]  found_c;

    // Clamp bucket count to 1..MAX_BUCKETS
    always_comb
    begin
        if (bcount_reg == '0)
            divisor = CNT_W'(1);
        else if (bcount_reg > CNT_W'(MAX_BUCKETS))
            divisor = CNT_W'(MAX_BUCKETS);
        else
            divisor = bcount_reg;
    end

    // Restoring division, one quotient bit per cycle
    assign trial = {rem_reg, mag_reg[KEY_W-1]};

    // Lowest free slot in the bucket
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--)
        begin
            if (!row_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign hit_now = cmp_en_reg && !hit_reg && row_reg[prev_idx_reg]
                     && (rd_key_reg == key_reg);
    assign kv_raddr = {bucket_reg, scnt_reg[SLOT_W-1:0]};

    // Result and write-back decision
    always_comb
    begin
        status_c   = ST_OK;
        found_c    = '0;
        kv_we      = 1'b0;
        vmem_we    = 1'b0;
        vmem_waddr = bucket_reg;
        vmem_wdata = row_reg;
        case (op_reg)
            OP_ADD:
            begin
                if (hit_reg)
                    status_c = ST_EXISTS;
                else if (!free_found)
                    status_c = ST_FULL;
                else
                begin
                    kv_we      = cmd.commit;
                    vmem_we    = cmd.commit;
                    vmem_wdata = row_reg | (SLOTS_PER_BUCKET'(1) << free_idx);
                end
            end
            OP_SEARCH:
            begin
                if (hit_reg)
                    found_c = hit_val_reg;
                else
                    status_c = ST_NOTFOUND;
            end
            OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    vmem_we    = cmd.commit;
                    vmem_wdata = row_reg & ~(SLOTS_PER_BUCKET'(1) << hit_idx_reg);
                end
                else
                    status_c = ST_NOTFOUND;
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
        if (cmd.clr_step)
        begin
            vmem_we    = 1'b1;
            vmem_waddr = clr_cnt_reg;
            vmem_wdata = '0;
        end
    end

    // Valid rows: clearing sweep, updates, row read
    always_ff @(posedge clk)
    begin
        if (vmem_we)
            vmem[vmem_waddr] <= vmem_wdata;
        if (cmd.scan_step && scnt_reg == '0)
            row_reg <= vmem[bucket_reg];
    end

    // Key and value store
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            kmem[{bucket_reg, free_idx}]   <= key_reg;
            valmem[{bucket_reg, free_idx}] <= val_reg;
        end
        if (cmd.scan_step)
        begin
            rd_key_reg <= kmem[kv_raddr];
            rd_val_reg <= valmem[kv_raddr];
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.op;
            key_reg <= req.key;
            val_reg <= req.value;
            neg_reg <= req.key[KEY_W-1];
            mag_reg <= req.key[KEY_W-1] ? (~req.key + KEY_W'(1)) : req.key;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= {mag_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_reg <= CNT_W'(trial - {1'b0, divisor});
            else
                rem_reg <= CNT_W'(trial);
        end
        if (cmd.fix)
        begin
            if (neg_reg && rem_reg != '0)
                bucket_reg <= BKT_W'(divisor - rem_reg);
            else
                bucket_reg <= BKT_W'(rem_reg);
        end
        if (hit_now)
        begin
            hit_idx_reg <= prev_idx_reg;
            hit_val_reg <= rd_val_reg;
        end
        if (cmd.scan_step)
            prev_idx_reg <= scnt_reg[SLOT_W-1:0];
        if (cmd.commit)
        begin
            rsp_reg.status      <= status_c;
            rsp_reg.found_value <= found_c;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg  <= CNT_W'(MAX_BUCKETS);
            clr_cnt_reg <= '0;
            dcnt_reg    <= '0;
            scnt_reg    <= '0;
            cmp_en_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bcount_reg <= cfg_data;
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + BKT_W'(1);
            if (cmd.load)
            begin
                dcnt_reg <= '0;
                scnt_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.div_step)
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                if (cmd.scan_step)
                    scnt_reg <= scnt_reg + SCNT_W'(1);
                if (hit_now)
                    hit_reg <= 1'b1;
            end
            cmp_en_reg <= cmd.scan_step && (scnt_reg < SCNT_W'(SLOTS_PER_BUCKET));
            done_reg   <= cmd.commit;
        end
    end

    assign sts.clr_done  = cmd.clr_step && (clr_cnt_reg == BKT_W'(MAX_BUCKETS - 1));
    assign sts.div_done  = cmd.div_step && (dcnt_reg == DCNT_W'(KEY_W - 1));
    assign sts.scan_done = (scnt_reg == SCNT_W'(SLOTS_PER_BUCKET));

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### hdl/division_hash_key_value_table_core.sv
`timescale 1ns / 1ps
// Key-value table, 256 buckets of 8 slots, bucket = key mod bucket_count.
// Command channel: req (op, key, value) is taken on a clock edge where
//   start is high and busy is low.
// Result: rsp (status, found_value) is shown for one cycle with done high;
//   the receiver cannot stall it and must take it in that cycle.
// Config: cfg_data (bucket_count) is written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while idle.
// Sequence: after accept, the bit-serial remainder unit runs, then a
//   negative key's remainder is folded, the bucket's slots are read and
//   compared one at a time through the single memory read port, any
//   update is written back and the result register is loaded. busy
//   falls as done rises, so a new command can follow at once; none is
//   taken while the last one is still in flight.
// Reset: bucket_count returns to 256 and a clearing pass wipes the valid
//   rows, one bucket per cycle; busy is high meanwhile.
module division_hash_key_value_table_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dhkv_pkg::dhkv_in_t         req,
    output logic                       done,
    output dhkv_pkg::dhkv_out_t        rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dhkv_pkg::CNT_W-1:0] cfg_data
);
    import dhkv_pkg::*;

    dhkv_cmd_t cmd;
    dhkv_sts_t sts;

    assign cfg_ready = 1'b1;

    dhkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    dhkv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

### hdl/dhkv_checker.sv
`timescale 1ns / 1ps
module dhkv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input dhkv_pkg::dhkv_out_t rsp
);
    import dhkv_pkg::*;

    // Result beat only arrives once the engine is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted command keeps the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accept did not make busy");

    // Results are single-cycle beats
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");

    // A returned value only comes with a success status
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.found_value != '0) |-> (rsp.status == ST_OK))
        else $error("value with failure status");

endmodule

bind division_hash_key_value_table_core dhkv_checker u_dhkv_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import dhkv_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    dhkv_in_t  req;
    logic      done;
    dhkv_out_t rsp;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    division_hash_key_value_table_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    localparam int CYCLE_LIMIT = 400000;

    // Shadow table state
    logic             tbl_valid [ENTRIES];
    logic [KEY_W-1:0] tbl_key   [ENTRIES];
    logic [VAL_W-1:0] tbl_val   [ENTRIES];
    int unsigned      shadow_buckets;

    dhkv_in_t  op_queue [$];
    dhkv_out_t expected_rsp [$];
    int        issued_cnt;
    int        mismatch_cnt;
    int        cycle_cnt;
    int        send_idle_pct;
    logic      pause_send;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Non-negative remainder of a signed key
    function automatic int unsigned key_bucket(logic [KEY_W-1:0] k);
        longint n, r, d;
        begin
            d = (shadow_buckets == 0) ? 1 : (shadow_buckets > MAX_BUCKETS ? MAX_BUCKETS
                                                                        : shadow_buckets);
            n = longint'($signed(k));
            r = n % d;
            if (r < 0)
                r += d;
            return int'(r);
        end
    endfunction

    // Apply one operation to the shadow table, return its response
    function automatic dhkv_out_t table_apply(dhkv_in_t it);
        dhkv_out_t o;
        int base, hit, free_i;
        begin
            o = '0;
            hit = -1;
            free_i = -1;
            base = key_bucket(it.key) * SLOTS_PER_BUCKET;
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (tbl_valid[base + s])
                begin
                    if (hit < 0 && tbl_key[base + s] == it.key)
                        hit = base + s;
                end
                else if (free_i < 0)
                    free_i = base + s;
            end
            case (it.op)
                OP_ADD:
                begin
                    if (hit >= 0)
                        o.status = ST_EXISTS;
                    else if (free_i < 0)
                        o.status = ST_FULL;
                    else
                    begin
                        tbl_valid[free_i] = 1'b1;
                        tbl_key[free_i] = it.key;
                        tbl_val[free_i] = it.value;
                    end
                end
                OP_SEARCH:
                begin
                    if (hit >= 0)
                        o.found_value = tbl_val[hit];
                    else
                        o.status = ST_NOTFOUND;
                end
                OP_REMOVE:
                begin
                    if (hit >= 0)
                        tbl_valid[hit] = 1'b0;
                    else
                        o.status = ST_NOTFOUND;
                end
                default: o.status = ST_OK;
            endcase
            return o;
        end
    endfunction

    function automatic dhkv_in_t mk_op(logic [1:0] op, logic [KEY_W-1:0] k,
                                       logic [VAL_W-1:0] v);
        dhkv_in_t it;
        begin
            it.op = op;
            it.key = k;
            it.value = v;
            return it;
        end
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        return {$urandom, $urandom};
    endfunction

    // Command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsp.push_back(table_apply(req));
                issued_cnt++;
            end
            if (!(start && busy))
            begin
                if (op_queue.size() > 0 && !pause_send &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    start <= 1'b1;
                    req   <= op_queue.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected result beat status=%0d value=%h",
                             rsp.status, rsp.found_value);
            end
            else
            begin
                dhkv_out_t exp_r;
                exp_r = expected_rsp.pop_front();
                if (rsp.status !== exp_r.status || rsp.found_value !== exp_r.found_value)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: status exp %0d got %0d, value exp %h got %h",
                                 exp_r.status, rsp.status, exp_r.found_value,
                                 rsp.found_value);
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL division_hash_key_value_table_core");
            $finish;
        end
    end

    // Wait until all queued ops are accepted and answered
    task automatic drain();
        begin
            while (op_queue.size() > 0 || start || expected_rsp.size() > 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    // Bucket count write, block idle
    task automatic set_buckets(logic [CNT_W-1:0] n);
        begin
            drain();
            pause_send = 1'b1;
            cfg_data  <= n;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            shadow_buckets = n;
            pause_send = 1'b0;
        end
    endtask

    // Random phase: small key pool so adds, hits, removes and full buckets all occur
    task automatic rand_phase(int count, int pool);
        logic [KEY_W-1:0] k;
        int sel;
        begin
            for (int i = 0; i < count; i++)
            begin
                sel = $urandom_range(99);
                if (sel < 10)
                    k = $urandom;
                else
                    k = $signed($urandom_range(2 * pool)) - pool;
                if (sel < 3)
                    k = {1'($urandom_range(1)), 31'($urandom)};
                op_queue.push_back(mk_op(2'($urandom_range(sel < 2 ? 3 : 2)), k, rand_val()));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pause_send = 1'b0;
        issued_cnt = 0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        send_idle_pct = 27;
        shadow_buckets = MAX_BUCKETS;
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every op, exists / not found / no-op
        op_queue.push_back(mk_op(OP_SEARCH, 32'h8000_0000, '0));
        op_queue.push_back(mk_op(OP_ADD, 32'h8000_0000, '1));
        op_queue.push_back(mk_op(OP_ADD, 32'h7FFF_FFFF, '0));
        op_queue.push_back(mk_op(OP_ADD, 32'hFFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0));
        op_queue.push_back(mk_op(OP_ADD, 32'h8000_0000, 64'h1));
        op_queue.push_back(mk_op(OP_SEARCH, 32'h8000_0000, '0));
        op_queue.push_back(mk_op(OP_SEARCH, 32'hFFFF_FFFF, '1));
        op_queue.push_back(mk_op(OP_NOP, 32'h7FFF_FFFF, '1));
        op_queue.push_back(mk_op(OP_REMOVE, 32'h7FFF_FFFF, '0));
        op_queue.push_back(mk_op(OP_REMOVE, 32'h7FFF_FFFF, '0));
        op_queue.push_back(mk_op(OP_SEARCH, 32'h7FFF_FFFF, '0));
        // Fill bucket 0 past capacity
        for (int i = 0; i < SLOTS_PER_BUCKET + 1; i++)
            op_queue.push_back(mk_op(OP_ADD, i * MAX_BUCKETS, rand_val()));
        op_queue.push_back(mk_op(OP_SEARCH, 7 * MAX_BUCKETS, '0));

        // Zero count acts as one bucket; no rehash across count changes
        set_buckets(9'd0);
        op_queue.push_back(mk_op(OP_ADD, 32'd5, 64'h55));
        op_queue.push_back(mk_op(OP_SEARCH, 32'hFFFF_FFFF, '0));
        op_queue.push_back(mk_op(OP_SEARCH, 32'h8000_0000, '0));
        rand_phase(120, 20);

        set_buckets(9'd1);
        rand_phase(80, 16);
        set_buckets(9'd511);
        rand_phase(160, 4000);
        set_buckets(9'd7);
        send_idle_pct = 76;
        rand_phase(200, 60);
        set_buckets(9'd256);
        rand_phase(130, 3000);
        set_buckets(9'd3);
        send_idle_pct = 0;
        rand_phase(130, 30);
        set_buckets(9'd257);
        rand_phase(110, 2000);

        pause_send = 1'b0;
        drain();
        repeat (50) @(posedge clk);
        if (mismatch_cnt == 0 && expected_rsp.size() == 0)
            $display("PASS division_hash_key_value_table_core");
        else
            $display("FAIL division_hash_key_value_table_core");
        $finish;
    end

endmodule
